// ===== design/mau_pkg.sv =====
// Shared types and constants for the modular arithmetic unit.
// Used by the divider, the modular accumulator and the top level; depends on nothing.
package mau_pkg;

  localparam int RES_W     = 63;  // residue and modulus width
  localparam int OPD_W     = 64;  // operand port width
  localparam int DVD_W     = 64;  // dividend width of the serial divider
  localparam int CMD_W     = 3;
  localparam int CNT_W     = 6;
  localparam int DEF_WIDTH = 64;

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INV = 3'd4;

  typedef enum logic [1:0] {
    MM_NOP,
    MM_CLR,
    MM_DBL,
    MM_ADD
  } mm_op_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_RED_A,
    ST_FIX_A,
    ST_LOAD_B,
    ST_RED_B,
    ST_FIX_B,
    ST_EXEC,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_MUL_FIN,
    ST_INV_LOAD,
    ST_INV_DIV,
    ST_INV_ADD,
    ST_INV_UPD,
    ST_INV_FIN,
    ST_DONE
  } state_t;

endpackage

// ===== design/mau_divider.sv =====
// Bit-serial restoring divider: one quotient bit per step, most significant first.
// Depends on mau_pkg.
module mau_divider import mau_pkg::*; (
  input  logic             clk,
  input  div_ctrl_t        ctrl,
  input  logic [DVD_W-1:0] dividend,
  input  logic [RES_W-1:0] divisor,
  output logic [RES_W-1:0] rem,
  output logic             qbit
);

  logic [DVD_W-1:0] dvd;
  logic [RES_W-1:0] dsr;
  logic [RES_W:0]   trial;
  logic [RES_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      qbit <= 1'b0;
    end else if (ctrl.step) begin
      dvd  <= {dvd[DVD_W-2:0], 1'b0};
      rem  <= ge ? diff[RES_W-1:0] : trial[RES_W-1:0];
      qbit <= ge;
    end
  end

endmodule

// ===== design/mau_mulmod.sv =====
// Modular accumulator for Horner-style shift-and-add products: clears, doubles or adds mod n.
// Depends on mau_pkg.
module mau_mulmod import mau_pkg::*; (
  input  logic             clk,
  input  mm_op_t           op,
  input  logic [RES_W-1:0] n,
  input  logic [RES_W-1:0] x,
  output logic [RES_W-1:0] acc
);

  logic [RES_W:0] sum;
  logic [RES_W:0] red;

  always_comb begin
    if (op == MM_DBL) begin
      sum = {acc, 1'b0};
    end else begin
      sum = {1'b0, acc} + {1'b0, x};
    end
    red = (sum >= {1'b0, n}) ? sum - {1'b0, n} : sum;
  end

  always_ff @(posedge clk) begin
    case (op)
      MM_CLR:  acc <= '0;
      MM_DBL:  acc <= red[RES_W-1:0];
      MM_ADD:  acc <= red[RES_W-1:0];
      default: acc <= acc;
    endcase
  end

endmodule

// ===== design/modular_arithmetic_unit.sv =====
// Top level of the modular arithmetic unit: sequencer, operand reduction and Euclid state.
// Depends on mau_pkg, mau_divider and mau_mulmod.
//
// The unit computes a+b, a-b, a*b, a/b (a times the inverse of b) or the inverse of a,
// all modulo the configured modulus, and returns the least non-negative residue. One
// item is worked on at a time. Each signed operand is first reduced by a bit-serial
// divider. Add and subtract then finish directly; a multiply runs the shift-and-add
// accumulator, one double and one conditional add per bit of b. An inverse runs the
// extended Euclidean algorithm, and in each of its iterations the serial divider
// produces the quotient one bit at a time while the accumulator folds the quotient
// times the coefficient. There are at most about 92 Euclid iterations, and a divide
// then multiplies a by the inverse. When no inverse exists, no_inverse is 1 and
// result is 0. A finished result sits in the output register until its transfer,
// and the unit starts on the next item meanwhile, only stalling when a second
// result is ready. The modulus is written through its own channel, which is always
// ready; a written zero acts as one.
module modular_arithmetic_unit import mau_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RES_W-1:0] modulus,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] command,
  input  logic [OPD_W-1:0] operand_a,
  input  logic [OPD_W-1:0] operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RES_W-1:0] result,
  output logic             no_inverse
);

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(RES_W - 1);

  state_t           state, state_next;
  logic [RES_W-1:0] mod_reg;
  logic [RES_W-1:0] n_eff;
  logic [CMD_W-1:0] cmd;
  logic [OPD_W-1:0] raw_a, raw_b;
  logic [RES_W-1:0] a_res, b_res;
  logic [RES_W-1:0] r0, r1, t0, t1;
  logic [RES_W-1:0] mul_y;
  logic [CNT_W-1:0] cnt;
  logic [RES_W-1:0] fin_res;
  logic             fin_flag;

  div_ctrl_t        div_ctrl;
  logic [DVD_W-1:0] div_dvd;
  logic [RES_W-1:0] div_dsr;
  logic [RES_W-1:0] div_rem;
  logic             div_qbit;
  mm_op_t           mm_op;
  logic [RES_W-1:0] mm_x;
  logic [RES_W-1:0] acc;

  logic [WIDTH-1:0] src, mag;
  logic             neg;
  logic [RES_W-1:0] fixed;
  logic [RES_W:0]   add_sum, add_red;
  logic [RES_W-1:0] sub_res;
  logic [RES_W-1:0] tn;

  assign cfg_ready = 1'b1;
  assign n_eff     = (mod_reg == '0) ? RES_W'(1) : mod_reg;

  // Sign-magnitude split of the operand being reduced.
  always_comb begin
    src   = (state == ST_LOAD_B || state == ST_FIX_B) ? raw_b[WIDTH-1:0] : raw_a[WIDTH-1:0];
    neg   = src[WIDTH-1];
    mag   = neg ? (~src + 1'b1) : src;
    fixed = (neg && div_rem != '0) ? n_eff - div_rem : div_rem;
  end

  // Modular add and subtract of the reduced operands, and the Euclid coefficient update.
  always_comb begin
    add_sum = {1'b0, a_res} + {1'b0, b_res};
    add_red = (add_sum >= {1'b0, n_eff}) ? add_sum - {1'b0, n_eff} : add_sum;
    sub_res = (a_res >= b_res) ? a_res - b_res : a_res + (n_eff - b_res);
    tn      = (t0 >= acc) ? t0 - acc : t0 + (n_eff - acc);
  end

  mau_divider u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .rem      (div_rem),
    .qbit     (div_qbit)
  );

  mau_mulmod u_mm (
    .clk (clk),
    .op  (mm_op),
    .n   (n_eff),
    .x   (mm_x),
    .acc (acc)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_LOAD_A;
      ST_LOAD_A:   state_next = ST_RED_A;
      ST_RED_A:    if (cnt == DIV_LAST) state_next = ST_FIX_A;
      ST_FIX_A:    state_next = ST_LOAD_B;
      ST_LOAD_B:   state_next = ST_RED_B;
      ST_RED_B:    if (cnt == DIV_LAST) state_next = ST_FIX_B;
      ST_FIX_B:    state_next = ST_EXEC;
      ST_EXEC: begin
        case (cmd)
          CMD_MUL: state_next = ST_MUL_DBL;
          CMD_DIV: state_next = ST_INV_LOAD;
          CMD_INV: state_next = ST_INV_LOAD;
          default: state_next = ST_DONE;
        endcase
      end
      ST_MUL_DBL:  state_next = ST_MUL_ADD;
      ST_MUL_ADD:  state_next = (cnt == MUL_LAST) ? ST_MUL_FIN : ST_MUL_DBL;
      ST_MUL_FIN:  state_next = ST_DONE;
      ST_INV_LOAD: state_next = (r1 == '0) ? ST_INV_FIN : ST_INV_DIV;
      ST_INV_DIV:  state_next = ST_INV_ADD;
      ST_INV_ADD:  state_next = (cnt == DIV_LAST) ? ST_INV_UPD : ST_INV_DIV;
      ST_INV_UPD:  state_next = ST_INV_LOAD;
      ST_INV_FIN: begin
        if (r0 == RES_W'(1) && cmd == CMD_DIV) begin
          state_next = ST_MUL_DBL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready      = (state == ST_IDLE);
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    div_dvd       = DVD_W'(mag);
    div_dsr       = n_eff;
    mm_op         = MM_NOP;
    mm_x          = a_res;
    case (state)
      ST_LOAD_A, ST_LOAD_B: div_ctrl.load = 1'b1;
      ST_RED_A, ST_RED_B:   div_ctrl.step = 1'b1;
      ST_EXEC:              if (cmd == CMD_MUL) mm_op = MM_CLR;
      ST_MUL_DBL:           mm_op = MM_DBL;
      ST_MUL_ADD:           if (mul_y[RES_W-1]) mm_op = MM_ADD;
      ST_INV_LOAD: begin
        div_ctrl.load = 1'b1;
        div_dvd       = DVD_W'(r0);
        div_dsr       = r1;
        mm_op         = MM_CLR;
      end
      ST_INV_DIV: begin
        div_ctrl.step = 1'b1;
        mm_op         = MM_DBL;
      end
      ST_INV_ADD: begin
        mm_x = t1;
        if (div_qbit) mm_op = MM_ADD;
      end
      ST_INV_FIN:           mm_op = MM_CLR;
      default:              mm_op = MM_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mod_reg   <= RES_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) mod_reg <= modulus;
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd   <= command;
          raw_a <= operand_a;
          raw_b <= operand_b;
        end
      end
      ST_LOAD_A, ST_LOAD_B: cnt <= '0;
      ST_RED_A, ST_RED_B:   cnt <= cnt + 1'b1;
      ST_FIX_A:             a_res <= fixed;
      ST_FIX_B:             b_res <= fixed;
      ST_EXEC: begin
        cnt      <= '0;
        fin_flag <= 1'b0;
        mul_y    <= b_res;
        r0       <= n_eff;
        r1       <= (cmd == CMD_DIV) ? b_res : a_res;
        t0       <= '0;
        t1       <= (n_eff == RES_W'(1)) ? '0 : RES_W'(1);
        case (cmd)
          CMD_ADD: fin_res <= add_red[RES_W-1:0];
          CMD_SUB: fin_res <= sub_res;
          default: fin_res <= '0;
        endcase
      end
      ST_MUL_ADD: begin
        mul_y <= {mul_y[RES_W-2:0], 1'b0};
        cnt   <= cnt + 1'b1;
      end
      ST_MUL_FIN:  fin_res <= acc;
      ST_INV_LOAD: cnt <= '0;
      ST_INV_ADD:  cnt <= cnt + 1'b1;
      ST_INV_UPD: begin
        r0 <= r1;
        r1 <= div_rem;
        t0 <= t1;
        t1 <= tn;
      end
      ST_INV_FIN: begin
        cnt   <= '0;
        mul_y <= t0;
        if (r0 != RES_W'(1)) begin
          fin_flag <= 1'b1;
          fin_res  <= '0;
        end else begin
          fin_res <= t0;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          result     <= fin_res;
          no_inverse <= fin_flag;
        end
      end
      default: cnt <= cnt;
    endcase
  end

endmodule

// ===== tb/tb_modular_arithmetic_unit.sv =====
// Self-checking testbench for the modular arithmetic unit.
// Depends on mau_pkg and the modular_arithmetic_unit RTL; a built-in predictor computes results.
`timescale 1ns / 1ps

module tb_modular_arithmetic_unit;
  import mau_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;  // covers the longest inverse plus divide
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam logic [RES_W-1:0] MOD_MAX = {RES_W{1'b1}};

  typedef struct {
    logic [RES_W-1:0] residue;
    logic             missing;
  } residue_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [RES_W-1:0] modulus = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] command = '0;
  logic [OPD_W-1:0] operand_a = '0;
  logic [OPD_W-1:0] operand_b = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [RES_W-1:0] result;
  logic             no_inverse;

  // Predictor state: the modulus register as last written.
  logic [RES_W-1:0] mod_reg = RES_W'(1);
  residue_t         pending_q[$];
  bit               steady = 1'b0;  // suppresses idling on both sides
  int               mismatches = 0;
  int               items_sent = 0;
  int               results_seen = 0;
  int               missing_seen = 0;
  int               mod_writes = 0;
  int               quiet_cycles = 0;

  modular_arithmetic_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .modulus(modulus),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .result(result), .no_inverse(no_inverse)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor. All residues are below n < 2^63, so a 64-bit sum of two
  // residues cannot wrap.
  // ---------------------------------------------------------------------
  function automatic logic [63:0] add_residue(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    logic [63:0] s;
    s = x + y;
    return (s >= n) ? s - n : s;
  endfunction

  function automatic logic [63:0] sub_residue(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    return (x >= y) ? x - y : x + (n - y);
  endfunction

  // Shift-and-add product, exact for any operands below n.
  function automatic logic [63:0] mul_residue(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    logic [63:0] acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = add_residue(acc, acc, n);
      if (y[i]) acc = add_residue(acc, x, n);
    end
    return acc;
  endfunction

  // Two's complement operand folded into [0, n).
  function automatic logic [63:0] fold_operand(logic [63:0] raw, logic [63:0] n);
    logic [63:0] mag;
    if (!raw[63]) return raw % n;
    mag = (64'd0 - raw) % n;
    return (mag == 0) ? 64'd0 : n - mag;
  endfunction

  // Extended Euclid with the coefficient kept modulo n; returns 0 when gcd is not one.
  function automatic bit invert_residue(logic [63:0] x, logic [63:0] n, output logic [63:0] inv);
    logic [63:0] r0, r1, t0, t1, q, rn, tn;
    r0 = n;
    r1 = x;
    t0 = '0;
    t1 = 64'd1 % n;
    while (r1 != 0) begin
      q  = r0 / r1;
      rn = r0 - q * r1;
      tn = sub_residue(t0, mul_residue(q % n, t1, n), n);
      r0 = r1;
      r1 = rn;
      t0 = t1;
      t1 = tn;
    end
    inv = (r0 == 1) ? t0 : 64'd0;
    return r0 == 1;
  endfunction

  function automatic residue_t predict_residue(logic [CMD_W-1:0] cmd, logic [63:0] raw_a,
                                               logic [63:0] raw_b);
    residue_t    exp_r;
    logic [63:0] n, a, b, inv, res;
    bit          ok;
    n   = (mod_reg == 0) ? 64'd1 : {1'b0, mod_reg};
    a   = fold_operand(raw_a, n);
    b   = fold_operand(raw_b, n);
    res = '0;
    exp_r.missing = 1'b0;
    case (cmd)
      CMD_ADD: res = add_residue(a, b, n);
      CMD_SUB: res = sub_residue(a, b, n);
      CMD_MUL: res = mul_residue(a, b, n);
      CMD_DIV: begin
        ok = invert_residue(b, n, inv);
        if (ok) res = mul_residue(a, inv, n);
        else exp_r.missing = 1'b1;
      end
      CMD_INV: begin
        ok = invert_residue(a, n, inv);
        if (ok) res = inv;
        else exp_r.missing = 1'b1;
      end
      default: res = '0;  // spare command codes give zero and no flag
    endcase
    exp_r.residue = res[RES_W-1:0];
    return exp_r;
  endfunction

  // ---------------------------------------------------------------------
  // Idling: each side pauses when a draw from 0 to 99 falls below 28, unless
  // the steady stretch is running.
  // ---------------------------------------------------------------------
  function automatic bit take_pause();
    return !steady && ($urandom_range(0, 99) < 28);
  endfunction

  always @(negedge clk) begin
    out_ready <= rst ? 1'b0 : !take_pause();
  end

  // Result checker: every output transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    residue_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (no_inverse) missing_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %0d no_inverse %0b", result, no_inverse);
      end else begin
        exp_r = pending_q.pop_front();
        if (result !== exp_r.residue || no_inverse !== exp_r.missing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d/%0b, expected %0d/%0b", result, no_inverse,
                     exp_r.residue, exp_r.missing);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transfer happens on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus tasks.
  // ---------------------------------------------------------------------

  // One input transfer; the prediction is queued at the accepting edge.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [63:0] a, logic [63:0] b);
    @(negedge clk);
    in_valid  <= 1'b1;
    command   <= cmd;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(predict_residue(cmd, a, b));
    items_sent++;
    while (take_pause()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // The modulus changes only with nothing in flight; every item gives a result,
  // so an empty queue means the unit is idle, and a short wait covers the tail.
  task automatic write_modulus(logic [RES_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    modulus   <= value;
    do @(posedge clk); while (!cfg_ready);
    mod_reg = value;
    mod_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Operands mix full-width random values, small signed values, values near
  // multiples of the modulus and random values already below the modulus.
  function automatic logic [63:0] pick_operand();
    logic [63:0] n;
    n = (mod_reg == 0) ? 64'd1 : {1'b0, mod_reg};
    case ($urandom_range(0, 5))
      0, 1: return {$urandom, $urandom};
      2:    return 64'($signed($urandom_range(0, 40)) - 20);
      3:    return n + 64'($signed($urandom_range(0, 4)) - 2);
      4:    return 64'd0 - n * $urandom_range(1, 3);
      default: return {$urandom, $urandom} % n;
    endcase
  endfunction

  task automatic send_random(int count);
    int          pick;
    logic [CMD_W-1:0] cmd;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 15);
      cmd  = (pick < 13) ? CMD_W'(pick % 5) : CMD_W'(pick - 8);
      send_item(cmd, pick_operand(), pick_operand());
    end
  endtask

  // Reset value of one: every residue is zero and zero is its own inverse.
  task automatic test_reset_modulus();
    send_item(CMD_INV, 64'd0, 64'd0);
    send_item(CMD_DIV, 64'd5, 64'h8000_0000_0000_0000);
    send_item(CMD_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  // A written zero must behave as a modulus of one.
  task automatic test_zero_modulus();
    write_modulus('0);
    send_item(CMD_INV, 64'd7, 64'd0);
    send_item(CMD_ADD, 64'h8000_0000_0000_0000, 64'd3);
  endtask

  // Operand extremes at the largest modulus, every command and the spare codes 5 and 7.
  task automatic test_extremes();
    write_modulus(MOD_MAX);
    send_item(CMD_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE);
    send_item(CMD_SUB, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(CMD_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_item(CMD_MUL, 64'h7FFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFE);
    send_item(CMD_INV, 64'd1, 64'd0);
    send_item(CMD_INV, 64'h7FFF_FFFF_FFFF_FFFE, 64'd0);
    send_item(CMD_DIV, 64'd12345, 64'd0);  // division by zero has no inverse
    send_item(CMD_INV, 64'd7, 64'd0);      // 7 divides 2^63-1, so no inverse
    send_item(CMD_SPARE5, 64'd9, 64'd9);
    send_item(CMD_SPARE7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Small prime and composite moduli give both found and missing inverses.
  task automatic test_small_moduli();
    write_modulus(63'd97);
    send_item(CMD_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 64'd96);
    send_item(CMD_INV, 64'd0, 64'd0);
    write_modulus(63'd2);
    send_item(CMD_INV, 64'd3, 64'd0);
    send_item(CMD_INV, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0);
    write_modulus(63'd36);
    send_item(CMD_DIV, 64'd5, 64'hFFFF_FFFF_FFFF_FFFC);
    send_item(CMD_DIV, 64'd5, 64'hFFFF_FFFF_FFFF_FFF9);
  endtask

  // Bulk of the run: 16-bit moduli keep the Euclid loop short.
  task automatic test_random_narrow();
    for (int p = 0; p < 16; p++) begin
      write_modulus(63'($urandom_range(1, 65535)));
      send_random(50);
    end
  endtask

  // Fewer items at wider moduli, where each inverse costs many iterations.
  task automatic test_random_wide();
    write_modulus(63'($urandom) | 63'h8000_0001);
    send_random(40);
    write_modulus(63'({$urandom, $urandom}) | 63'h4000_0000_0000_0000);
    send_random(25);
    write_modulus(MOD_MAX);
    send_random(15);
  endtask

  // A stretch with both sides always ready.
  task automatic test_steady_stream();
    steady = 1'b1;
    write_modulus(63'd65521);
    send_random(60);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_modulus();
    test_zero_modulus();
    test_extremes();
    test_small_moduli();
    test_steady_stream();
    test_random_narrow();
    test_random_wide();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_q.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d results never arrived", pending_q.size());
    end
    $display("Covered %0d items across %0d modulus writes; %0d results checked.",
             items_sent, mod_writes, results_seen);
    $display("Results with a missing inverse: %0d; mismatches: %0d.", missing_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mau_pkg.sv
design/mau_divider.sv
design/mau_mulmod.sv
design/modular_arithmetic_unit.sv
tb/tb_modular_arithmetic_unit.sv
